FILE: hw/rtl/etcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edge-triggered capture statistics package
// Shared constants, register map and reset values for the capture block.
// ----------------------------------------------------------------------------
package etcs_pkg;

	localparam int unsigned NUM_CH         = 4;
	localparam int unsigned FIELDS_PER_CH  = 3;
	localparam int unsigned CODE_BITS_DEF  = 24;
	localparam int unsigned MAX_FRAMES_DEF = 1024;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W  = 3;

	localparam int unsigned TRIG_CH_W   = 2;
	localparam int unsigned TRIG_EDGE_W = 2;
	localparam int unsigned CAP_LEN_W   = 11;
	localparam int unsigned SKIP_W      = 10;

	typedef enum logic [IDX_W-1:0] {
		REG_TRIG_CH   = 3'd0,
		REG_TRIG_EDGE = 3'd1,
		REG_CAP_LEN   = 3'd2,
		REG_SKIP      = 3'd3,
		REG_REPEAT    = 3'd4
	} reg_idx_t;

	localparam logic [TRIG_EDGE_W-1:0] EDGE_ANY  = 2'd0;
	localparam logic [TRIG_EDGE_W-1:0] EDGE_RISE = 2'd1;
	localparam logic [TRIG_EDGE_W-1:0] EDGE_FALL = 2'd2;

	localparam logic [TRIG_CH_W-1:0]   RST_TRIG_CH   = 2'd0;
	localparam logic [TRIG_EDGE_W-1:0] RST_TRIG_EDGE = EDGE_RISE;
	localparam logic [CAP_LEN_W-1:0]   RST_CAP_LEN   = 11'd1024;
	localparam logic [SKIP_W-1:0]      RST_SKIP      = 10'd512;
	localparam logic                   RST_REPEAT    = 1'b1;

endpackage
`default_nettype wire

FILE: hw/rtl/edge_triggered_capture_stats_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edge-triggered capture statistics
// Watches one channel of a four-channel code stream for an edge, captures a
// window of frames and reports per-channel minimum, maximum and mean.
// ----------------------------------------------------------------------------
// A frame that arrives while the block waits for its trigger, or after it has
// stopped, is accepted with the input kept ready. A captured frame makes the
// input busy while each channel in turn goes through the shared min, max and
// accumulate step. The frame that closes a capture then waits for the
// previous result to be taken and runs the shared restoring divider, one
// quotient bit per cycle and one channel after the other, over a dividend of
// SUM_W = CODE_BITS + clog2(MAX_FRAMES) bits.
module edge_triggered_capture_stats_top #(
	parameter int unsigned MAX_FRAMES = etcs_pkg::MAX_FRAMES_DEF,
	parameter int unsigned CODE_BITS  = etcs_pkg::CODE_BITS_DEF,
	localparam int unsigned IN_W  = ((etcs_pkg::NUM_CH * CODE_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_W =
		((etcs_pkg::NUM_CH * etcs_pkg::FIELDS_PER_CH * CODE_BITS + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// ch1_code, ch2_code, ch3_code, ch4_code
	input  wire logic [IN_W-1:0]             s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// min_ch1, max_ch1, avg_ch1, min_ch2, max_ch2, avg_ch2,
	// min_ch3, max_ch3, avg_ch3, min_ch4, max_ch4, avg_ch4
	output logic [OUT_W-1:0]                 m_tdata,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [etcs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [etcs_pkg::DATA_W-1:0] pwdata,
	output logic [etcs_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	localparam int unsigned NCH    = etcs_pkg::NUM_CH;
	localparam int unsigned CB     = CODE_BITS;
	localparam int unsigned CH_W   = $clog2(NCH);
	localparam int unsigned FT_W   = $clog2(MAX_FRAMES + 1);
	localparam int unsigned CMP_W  = (FT_W > etcs_pkg::CAP_LEN_W) ? FT_W : etcs_pkg::CAP_LEN_W;
	localparam int unsigned SUM_W  = CB + $clog2(MAX_FRAMES);
	localparam int unsigned BIT_W  = $clog2(SUM_W);
	localparam int unsigned FLAT_W = NCH * etcs_pkg::FIELDS_PER_CH * CB;

	localparam logic signed [CB-1:0] CODE_MAXV = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CODE_MINV = {1'b1, {(CB-1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_WAIT,
		S_LOAD,
		S_DIV,
		S_STORE
	} state_t;

	logic [etcs_pkg::TRIG_CH_W-1:0]   trig_ch_q;
	logic [etcs_pkg::TRIG_EDGE_W-1:0] trig_edge_q;
	logic [etcs_pkg::CAP_LEN_W-1:0]   cap_len_q;
	logic [etcs_pkg::SKIP_W-1:0]      skip_q;
	logic                             repeat_q;

	state_t                  state_q;
	logic [CH_W-1:0]         ch_q;
	logic                    running_q;
	logic                    armed_q;
	logic                    trig_q;
	logic                    in_win_q;
	logic signed [CB-1:0]    ref_q;
	logic [FT_W-1:0]         frames_q;
	logic [FT_W-1:0]         count_q;
	logic signed [CB-1:0]    frame_q   [NCH];
	logic signed [CB-1:0]    win_min_q [NCH];
	logic signed [CB-1:0]    win_max_q [NCH];
	logic signed [SUM_W-1:0] win_sum_q [NCH];
	logic [CB-1:0]           res_min_q [NCH];
	logic [CB-1:0]           res_max_q [NCH];
	logic [CB-1:0]           res_avg_q [NCH];
	logic                    out_valid_q;
	logic [SUM_W-1:0]        div_q;
	logic [FT_W-1:0]         rem_q;
	logic [BIT_W-1:0]        bit_q;
	logic                    neg_q;

	logic                    accept;
	logic                    cfg_write;
	etcs_pkg::reg_idx_t      cfg_idx;
	logic signed [CB-1:0]    in_code [NCH];
	logic signed [CB-1:0]    now_code;
	logic signed [CB-1:0]    ref_use;
	logic                    fire;
	logic                    skip_ok;
	logic [CMP_W-1:0]        eff_len;
	logic [CMP_W-1:0]        frames_next;
	logic                    cap_done;
	logic signed [CB-1:0]    cur_code;
	logic signed [SUM_W-1:0] cur_ext;
	logic signed [SUM_W-1:0] sel_sum;
	logic [SUM_W-1:0]        sum_mag;
	logic [FT_W:0]           trial;
	logic                    trial_ge;
	logic [FT_W-1:0]         rem_next;
	logic [CB-1:0]           quo_trunc;
	logic [CB-1:0]           avg_val;
	logic [FLAT_W-1:0]       out_flat;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_W'(out_flat);
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign cfg_idx   = etcs_pkg::reg_idx_t'(paddr[etcs_pkg::ADDR_W-1:2]);

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			in_code[c] = s_tdata[c*CB +: CB];
		end
		now_code = in_code[trig_ch_q];
		ref_use  = armed_q ? ref_q : now_code;
		case (trig_edge_q)
			etcs_pkg::EDGE_ANY:  fire = (now_code != ref_use);
			etcs_pkg::EDGE_RISE: fire = (now_code > ref_use);
			etcs_pkg::EDGE_FALL: fire = (now_code < ref_use);
			default:             fire = 1'b0;
		endcase
	end

	always_comb begin
		skip_ok = (CMP_W'(frames_q) >= CMP_W'(skip_q));
		if (cap_len_q == '0) begin
			eff_len = CMP_W'(1);
		end else if (CMP_W'(cap_len_q) > CMP_W'(MAX_FRAMES)) begin
			eff_len = CMP_W'(MAX_FRAMES);
		end else begin
			eff_len = CMP_W'(cap_len_q);
		end
		frames_next = CMP_W'(frames_q) + CMP_W'(1);
		cap_done    = (frames_next >= eff_len);
	end

	always_comb begin
		cur_code  = frame_q[ch_q];
		cur_ext   = {{(SUM_W-CB){cur_code[CB-1]}}, cur_code};
		sel_sum   = win_sum_q[ch_q];
		sum_mag   = sel_sum[SUM_W-1] ? (~$unsigned(sel_sum) + 1'b1) : $unsigned(sel_sum);
		trial     = {rem_q, div_q[SUM_W-1]};
		trial_ge  = (trial >= {1'b0, count_q});
		rem_next  = trial_ge ? FT_W'(trial - {1'b0, count_q}) : FT_W'(trial);
		quo_trunc = div_q[CB-1:0];
		avg_val   = neg_q ? (~quo_trunc + 1'b1) : quo_trunc;
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			out_flat[(3*c)*CB +: CB]   = res_min_q[c];
			out_flat[(3*c+1)*CB +: CB] = res_max_q[c];
			out_flat[(3*c+2)*CB +: CB] = res_avg_q[c];
		end
	end

	always_comb begin
		case (cfg_idx)
			etcs_pkg::REG_TRIG_CH:   prdata = etcs_pkg::DATA_W'(trig_ch_q);
			etcs_pkg::REG_TRIG_EDGE: prdata = etcs_pkg::DATA_W'(trig_edge_q);
			etcs_pkg::REG_CAP_LEN:   prdata = etcs_pkg::DATA_W'(cap_len_q);
			etcs_pkg::REG_SKIP:      prdata = etcs_pkg::DATA_W'(skip_q);
			etcs_pkg::REG_REPEAT:    prdata = etcs_pkg::DATA_W'(repeat_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ch_q   <= etcs_pkg::RST_TRIG_CH;
			trig_edge_q <= etcs_pkg::RST_TRIG_EDGE;
			cap_len_q   <= etcs_pkg::RST_CAP_LEN;
			skip_q      <= etcs_pkg::RST_SKIP;
			repeat_q    <= etcs_pkg::RST_REPEAT;
		end else if (cfg_write) begin
			case (cfg_idx)
				etcs_pkg::REG_TRIG_CH:   trig_ch_q   <= pwdata[etcs_pkg::TRIG_CH_W-1:0];
				etcs_pkg::REG_TRIG_EDGE: trig_edge_q <= pwdata[etcs_pkg::TRIG_EDGE_W-1:0];
				etcs_pkg::REG_CAP_LEN:   cap_len_q   <= pwdata[etcs_pkg::CAP_LEN_W-1:0];
				etcs_pkg::REG_SKIP:      skip_q      <= pwdata[etcs_pkg::SKIP_W-1:0];
				etcs_pkg::REG_REPEAT:    repeat_q    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			running_q   <= 1'b1;
			armed_q     <= 1'b0;
			trig_q      <= 1'b0;
			in_win_q    <= 1'b0;
			ref_q       <= '0;
			frames_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			bit_q       <= '0;
			for (int c = 0; c < NCH; c++) begin
				win_min_q[c] <= CODE_MAXV;
				win_max_q[c] <= CODE_MINV;
				win_sum_q[c] <= '0;
			end
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && running_q) begin
						if (trig_q) begin
							for (int c = 0; c < NCH; c++) begin
								frame_q[c] <= in_code[c];
							end
							in_win_q <= skip_ok;
							ch_q     <= '0;
							state_q  <= S_UPD;
						end else begin
							ref_q   <= now_code;
							armed_q <= 1'b1;
							trig_q  <= fire;
						end
					end
				end
				S_UPD: begin
					if (in_win_q) begin
						if (cur_code < win_min_q[ch_q]) begin
							win_min_q[ch_q] <= cur_code;
						end
						if (cur_code > win_max_q[ch_q]) begin
							win_max_q[ch_q] <= cur_code;
						end
						win_sum_q[ch_q] <= win_sum_q[ch_q] + cur_ext;
					end
					if (ch_q == CH_W'(NCH - 1)) begin
						frames_q <= FT_W'(frames_next);
						count_q  <= count_q + FT_W'(in_win_q);
						state_q  <= cap_done ? S_WAIT : S_IDLE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (!out_valid_q) begin
						ch_q    <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					div_q   <= sum_mag;
					neg_q   <= sel_sum[SUM_W-1];
					rem_q   <= '0;
					bit_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_q <= {div_q[SUM_W-2:0], trial_ge};
					rem_q <= rem_next;
					if (bit_q == BIT_W'(SUM_W - 1)) begin
						state_q <= S_STORE;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				S_STORE: begin
					if (count_q != '0) begin
						res_min_q[ch_q] <= win_min_q[ch_q];
						res_max_q[ch_q] <= win_max_q[ch_q];
						res_avg_q[ch_q] <= avg_val;
					end else begin
						res_min_q[ch_q] <= '0;
						res_max_q[ch_q] <= '0;
						res_avg_q[ch_q] <= '0;
					end
					win_min_q[ch_q] <= CODE_MAXV;
					win_max_q[ch_q] <= CODE_MINV;
					win_sum_q[ch_q] <= '0;
					if (ch_q == CH_W'(NCH - 1)) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						frames_q    <= '0;
						trig_q      <= 1'b0;
						running_q   <= repeat_q;
						state_q     <= S_IDLE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/etcs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Edge-triggered capture statistics checker
// Port-level properties of the capture block, bound to its top level.
// ----------------------------------------------------------------------------
module etcs_checker #(
	parameter int unsigned CODE_BITS = etcs_pkg::CODE_BITS_DEF,
	parameter int unsigned OUT_W     = etcs_pkg::NUM_CH * etcs_pkg::FIELDS_PER_CH * CODE_BITS
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	localparam int unsigned CB = CODE_BITS;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result request changed while stalled.");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("Result appeared without a preceding busy cycle.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("Input side went busy without an accepted request.");

	for (genvar c = 0; c < etcs_pkg::NUM_CH; c++) begin : g_ch
		logic signed [CB-1:0] mn;
		logic signed [CB-1:0] mx;
		logic signed [CB-1:0] av;

		assign mn = m_tdata[(3*c)*CB +: CB];
		assign mx = m_tdata[(3*c+1)*CB +: CB];
		assign av = m_tdata[(3*c+2)*CB +: CB];

		a_order: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid |-> (mn <= av) && (av <= mx))
			else $error("Channel statistics out of order.");
	end

endmodule

bind edge_triggered_capture_stats_top etcs_checker #(
	.CODE_BITS(CODE_BITS),
	.OUT_W(OUT_W)
) u_etcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire
